[rtl/trc_pkg.sv]
// Shared types and constants for the token pattern classifier.
package trc_pkg;

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChPoint = 8'h2E;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5A;
    localparam logic [7:0] ChLoA   = 8'h61;
    localparam logic [7:0] ChLoZ   = 8'h7A;
    localparam logic [7:0] ChUpE   = 8'h45;
    localparam logic [7:0] ChLoE   = 8'h65;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } trc_in_t;

    typedef struct packed {
        logic is_integer;
        logic is_string;
        logic is_common_float;
        logic is_dot_float;
        logic is_sci_float;
        logic is_any_float;
        logic is_identifier;
    } trc_out_t;

    typedef struct packed {
        logic digit;
        logic letter;
        logic sign;
        logic point;
        logic quote;
        logic exp_mark;
    } trc_class_t;

    typedef enum logic [1:0] {
        INT_START, INT_SIGN, INT_DIGITS, INT_DEAD
    } int_phase_t;

    typedef enum logic [1:0] {
        STR_START, STR_BODY, STR_CLOSED, STR_DEAD
    } str_phase_t;

    typedef enum logic [2:0] {
        CF_START, CF_SIGN, CF_INT, CF_POINT, CF_FRAC, CF_DEAD
    } cfloat_phase_t;

    typedef enum logic [2:0] {
        DF_START, DF_SIGN, DF_POINT, DF_DIGITS, DF_DEAD
    } dfloat_phase_t;

    typedef enum logic [3:0] {
        SF_START, SF_SIGN, SF_INT, SF_POINT, SF_FRAC,
        SF_EXP, SF_EXP_SIGN, SF_EXP_DIGITS, SF_DEAD
    } sfloat_phase_t;

    typedef enum logic [1:0] {
        ID_START, ID_BODY, ID_DEAD
    } ident_phase_t;

endpackage

[rtl/trc_char_class.sv]
// Character classifier: decodes one 8-bit code into its pattern classes.
module trc_char_class
    import trc_pkg::*;
(
    input  logic [7:0]  ch,
    output trc_class_t  cls
);

    always_comb begin
        cls.digit    = (ch >= ChZero) && (ch <= ChNine);
        cls.letter   = ((ch >= ChUpA) && (ch <= ChUpZ)) || ((ch >= ChLoA) && (ch <= ChLoZ));
        cls.sign     = (ch == ChPlus) || (ch == ChMinus);
        cls.point    = (ch == ChPoint);
        cls.quote    = (ch == ChQuote);
        cls.exp_mark = (ch == ChUpE) || (ch == ChLoE);
    end

endmodule

[rtl/trc_phase_bank.sv]
// Six pattern automata: phase registers, next-phase logic and match flags.
module trc_phase_bank
    import trc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       last,
    input  trc_class_t cls,
    output trc_out_t   flags
);

    int_phase_t    int_phase_reg,    int_phase_next;
    str_phase_t    str_phase_reg,    str_phase_next;
    cfloat_phase_t cfloat_phase_reg, cfloat_phase_next;
    dfloat_phase_t dfloat_phase_reg, dfloat_phase_next;
    sfloat_phase_t sfloat_phase_reg, sfloat_phase_next;
    ident_phase_t  ident_phase_reg,  ident_phase_next;

    always_comb begin
        unique case (int_phase_reg)
            INT_START: int_phase_next = cls.sign ? INT_SIGN :
                                        (cls.digit ? INT_DIGITS : INT_DEAD);
            INT_SIGN, INT_DIGITS: int_phase_next = cls.digit ? INT_DIGITS : INT_DEAD;
            default: int_phase_next = INT_DEAD;
        endcase

        unique case (str_phase_reg)
            STR_START: str_phase_next = cls.quote ? STR_BODY : STR_DEAD;
            STR_BODY, STR_CLOSED: str_phase_next = cls.quote ? STR_CLOSED : STR_BODY;
            default: str_phase_next = STR_DEAD;
        endcase

        unique case (cfloat_phase_reg)
            CF_START: cfloat_phase_next = cls.sign ? CF_SIGN : (cls.digit ? CF_INT : CF_DEAD);
            CF_SIGN:  cfloat_phase_next = cls.digit ? CF_INT : CF_DEAD;
            CF_INT:   cfloat_phase_next = cls.digit ? CF_INT : (cls.point ? CF_POINT : CF_DEAD);
            CF_POINT, CF_FRAC: cfloat_phase_next = cls.digit ? CF_FRAC : CF_DEAD;
            default:  cfloat_phase_next = CF_DEAD;
        endcase

        unique case (dfloat_phase_reg)
            DF_START: dfloat_phase_next = cls.sign ? DF_SIGN : (cls.point ? DF_POINT : DF_DEAD);
            DF_SIGN:  dfloat_phase_next = cls.point ? DF_POINT : DF_DEAD;
            DF_POINT, DF_DIGITS: dfloat_phase_next = cls.digit ? DF_DIGITS : DF_DEAD;
            default:  dfloat_phase_next = DF_DEAD;
        endcase

        unique case (sfloat_phase_reg)
            SF_START: sfloat_phase_next = cls.sign ? SF_SIGN : (cls.digit ? SF_INT : SF_DEAD);
            SF_SIGN:  sfloat_phase_next = cls.digit ? SF_INT : SF_DEAD;
            SF_INT:   sfloat_phase_next = cls.digit ? SF_INT : (cls.point ? SF_POINT : SF_DEAD);
            SF_POINT: sfloat_phase_next = cls.digit ? SF_FRAC : SF_DEAD;
            SF_FRAC:  sfloat_phase_next = cls.digit ? SF_FRAC :
                                          (cls.exp_mark ? SF_EXP : SF_DEAD);
            SF_EXP:   sfloat_phase_next = cls.sign ? SF_EXP_SIGN :
                                          (cls.digit ? SF_EXP_DIGITS : SF_DEAD);
            SF_EXP_SIGN, SF_EXP_DIGITS:
                      sfloat_phase_next = cls.digit ? SF_EXP_DIGITS : SF_DEAD;
            default:  sfloat_phase_next = SF_DEAD;
        endcase

        unique case (ident_phase_reg)
            ID_START: ident_phase_next = cls.letter ? ID_BODY : ID_DEAD;
            ID_BODY:  ident_phase_next = (cls.letter || cls.digit) ? ID_BODY : ID_DEAD;
            default:  ident_phase_next = ID_DEAD;
        endcase
    end

    // Flags reflect the phases after this character.
    always_comb begin
        flags.is_integer      = (int_phase_next == INT_DIGITS);
        flags.is_string       = (str_phase_next == STR_CLOSED);
        flags.is_common_float = (cfloat_phase_next == CF_FRAC);
        flags.is_dot_float    = (dfloat_phase_next == DF_DIGITS);
        flags.is_sci_float    = (sfloat_phase_next == SF_EXP_DIGITS);
        flags.is_any_float    = flags.is_common_float || flags.is_dot_float
                                || flags.is_sci_float;
        flags.is_identifier   = (ident_phase_next == ID_BODY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_phase_reg    <= INT_START;
            str_phase_reg    <= STR_START;
            cfloat_phase_reg <= CF_START;
            dfloat_phase_reg <= DF_START;
            sfloat_phase_reg <= SF_START;
            ident_phase_reg  <= ID_START;
        end else if (adv) begin
            if (last) begin
                // Token done: rewind every automaton.
                int_phase_reg    <= INT_START;
                str_phase_reg    <= STR_START;
                cfloat_phase_reg <= CF_START;
                dfloat_phase_reg <= DF_START;
                sfloat_phase_reg <= SF_START;
                ident_phase_reg  <= ID_START;
            end else begin
                int_phase_reg    <= int_phase_next;
                str_phase_reg    <= str_phase_next;
                cfloat_phase_reg <= cfloat_phase_next;
                dfloat_phase_reg <= dfloat_phase_next;
                sfloat_phase_reg <= sfloat_phase_next;
                ident_phase_reg  <= ident_phase_next;
            end
        end
    end

    a_rewind_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && last |=> int_phase_reg == INT_START && str_phase_reg == STR_START
            && cfloat_phase_reg == CF_START && dfloat_phase_reg == DF_START
            && sfloat_phase_reg == SF_START && ident_phase_reg == ID_START)
        else $error("phases not rewound after last character");

    a_sfloat_dead_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !last && sfloat_phase_reg == SF_DEAD |=> sfloat_phase_reg == SF_DEAD)
        else $error("sci float phase left dead phase inside a token");

    // Flags only mean something while a character is being consumed.
    a_int_ident_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |-> !(flags.is_integer && flags.is_identifier))
        else $error("integer and identifier matched together");

endmodule

[rtl/token_regex_classifier_unit.sv]
// Top level: input register, pattern automata and result register.
//
// Usage: each s_ word carries one token character (s_data.ch) and a flag
// marking the token's final character (s_data.last). Words without the
// flag update the six pattern automata and give no result. A word with
// the flag gives one m_ word with the whole-token match flags and the
// float union, and rewinds all automata for the next token.
// Result path: a final character is held in the input register, then its
// match flags are loaded into the result register that drives m_valid.
// Throughput: one character per cycle unless a final character stalls; the
// phase update of the six automata is a single short next-state step between the two registers.
// Reset: aresetn, synchronous, clears both registers' valid bits and puts
// every automaton in its start phase.
// Stall: while m_ready is low the result register holds; further
// non-final characters still advance, and a final character waits in the
// input register, lowering s_ready until the result slot frees.
module token_regex_classifier_unit
    import trc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  trc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output trc_out_t m_data
);

    logic       in_valid_reg;
    trc_in_t    in_reg;
    logic       out_valid_reg;
    trc_out_t   out_reg;
    logic       out_free;
    logic       adv;
    trc_class_t cls;
    trc_out_t   flags;

    assign out_free = !out_valid_reg || m_ready;
    assign adv      = in_valid_reg && (!in_reg.last || out_free);
    assign s_ready  = !in_valid_reg || adv;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    trc_char_class u_class (
        .ch  (in_reg.ch),
        .cls (cls)
    );

    trc_phase_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .last    (in_reg.last),
        .cls     (cls),
        .flags   (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && in_reg.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_reg.last) begin
            out_reg <= flags;
        end
    end

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_reg.last |=> out_valid_reg)
        else $error("final character gave no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !(adv && in_reg.last))
        else $error("pending result overwritten");

    a_held_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_reg))
        else $error("stalled word lost from input register");

    a_float_union: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_reg.is_any_float == (out_reg.is_common_float
            || out_reg.is_dot_float || out_reg.is_sci_float))
        else $error("float union flag mismatch");

endmodule
